// ===== rtl/core/ocg_pkg.sv =====
// Shared types and constants for the output channel guard with dim ramp.
// Used by the controller, the datapath and the top level.
package ocg_pkg;

  localparam int unsigned MAX_DURATION_SEC_DEF  = 86400;
  localparam int unsigned DEFAULT_MAX_ON_MS_DEF = 3600000;

  localparam int unsigned RAMP_Q_W  = 10;
  localparam int unsigned DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RAMP_Q_W - 1);

  localparam logic [31:0] RECIP_1000 = 32'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_CHANGED  = 2'd1;
  localparam logic [1:0] EV_REJECTED = 2'd2;

  localparam logic [1:0] RS_NONE    = 2'd0;
  localparam logic [1:0] RS_MISSING = 2'd1;
  localparam logic [1:0] RS_TIMER   = 2'd2;
  localparam logic [1:0] RS_MAX_ON  = 2'd3;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic MODE_SWITCH = 1'b0;

  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic step;
    logic update;
  } ocg_cmd_t;

  typedef struct packed {
    logic slot_free;
  } ocg_sts_t;

endpackage

// ===== rtl/core/ocg_ctrl.sv =====
// Sequencer for one item: load, prepare, multiply, ramp division, update.
// Depends on ocg_pkg for the command and status structs.
module ocg_ctrl import ocg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ocg_sts_t sts,
  output ocg_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_DIV, ST_UPD
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (sts.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.prep   = (state_r == ST_PREP);
  assign cmd.mul    = (state_r == ST_MUL);
  assign cmd.step   = (state_r == ST_DIV);
  assign cmd.update = (state_r == ST_UPD) && sts.slot_free;

endmodule

// ===== rtl/core/ocg_dp.sv =====
// Channel state, counters, ramp arithmetic and the result register.
// Depends on ocg_pkg; driven by commands from ocg_ctrl.
module ocg_dp import ocg_pkg::*; #(
  parameter int unsigned MAX_DURATION_SEC  = MAX_DURATION_SEC_DEF,
  parameter int unsigned DEFAULT_MAX_ON_MS = DEFAULT_MAX_ON_MS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ocg_cmd_t           cmd,
  output ocg_sts_t           sts,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_cmd,
  input  logic [31:0]        in_now_ms,
  input  logic               in_state_given,
  input  logic               in_on_wanted,
  input  logic               in_has_pwm,
  input  logic signed [15:0] in_pwm_request,
  input  logic               in_level_given,
  input  logic signed [15:0] in_level_request,
  input  logic               in_ramp_given,
  input  logic [15:0]        in_ramp_seconds,
  input  logic               in_timer_given,
  input  logic [15:0]        in_duration_seconds,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_event_kind,
  output logic [1:0]         out_reason_code,
  output logic               out_output_on,
  output logic [7:0]         out_pwm_duty,
  output logic [9:0]         out_dim_level,
  output logic               out_was_cutoff,
  output logic               out_ramp_active,
  output logic [31:0]        out_cycle_total,
  output logic [31:0]        out_on_seconds_total,
  output logic [31:0]        out_on_seconds_live,
  output logic [31:0]        out_cutoff_total
);

  localparam logic [16:0] MAX_SEC = (MAX_DURATION_SEC > 65535) ? 17'd65535
                                                               : 17'(MAX_DURATION_SEC);
  localparam logic [31:0] DEF_LIM = 32'(DEFAULT_MAX_ON_MS);

  logic        mode_r;
  logic [31:0] limit_r;

  logic        lit_r, off_armed_r, ramp_running_r;
  logic [7:0]  duty_r;
  logic [9:0]  level_r, ramp_origin_r, ramp_target_r;
  logic [31:0] lit_since_r, off_deadline_r, ramp_begin_r, ramp_finish_r;
  logic [31:0] cycles_r, on_sum_r, cutoffs_r;

  logic        c_cmd_r, c_hs_r, c_son_r, c_hp_r, c_hl_r, c_hr_r, c_hd_r;
  logic [31:0] c_now_r;
  logic signed [15:0] c_pwm_r, c_lvl_r;
  logic [15:0] c_rsec_r, c_dsec_r;

  logic [31:0] d_r, span_r, pos_r, rms_r, dms_r, sec_r, rem_sub;
  logic [9:0]  mag_r, q_r, low_r;
  logic [32:0] rem_r, rem_sh;
  logic [63:0] recip_prod;
  logic [41:0] ramp_prod;
  logic [16:0] rsec_c, dsec_c;
  logic [31:0] span_c, pos_c;
  logic [31:0] dl_gap, fin_gap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      limit_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[0];
        CFG_LIMIT: limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_cmd_r  <= in_cmd;
      c_now_r  <= in_now_ms;
      c_hs_r   <= in_state_given;
      c_son_r  <= in_on_wanted;
      c_hp_r   <= in_has_pwm;
      c_pwm_r  <= in_pwm_request;
      c_hl_r   <= in_level_given;
      c_lvl_r  <= in_level_request;
      c_hr_r   <= in_ramp_given;
      c_rsec_r <= in_ramp_seconds;
      c_hd_r   <= in_timer_given;
      c_dsec_r <= in_duration_seconds;
    end
  end

  assign span_c  = ramp_finish_r - ramp_begin_r;
  assign pos_c   = c_now_r - ramp_begin_r;
  assign dl_gap  = c_now_r - off_deadline_r;
  assign fin_gap = c_now_r - ramp_finish_r;
  assign rsec_c = ({1'b0, c_rsec_r} > MAX_SEC) ? MAX_SEC : {1'b0, c_rsec_r};
  assign dsec_c = ({1'b0, c_dsec_r} > MAX_SEC) ? MAX_SEC : {1'b0, c_dsec_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      d_r    <= c_now_r - lit_since_r;
      span_r <= span_c;
      pos_r  <= (pos_c > span_c) ? span_c : pos_c;
      mag_r  <= (ramp_target_r >= ramp_origin_r) ? ramp_target_r - ramp_origin_r
                                                 : ramp_origin_r - ramp_target_r;
      rms_r  <= 32'(rsec_c * 32'd1000);
      dms_r  <= 32'(dsec_c * 32'd1000);
    end
  end

  assign recip_prod = 64'(d_r) * 64'(RECIP_1000);
  assign ramp_prod  = 42'(mag_r) * 42'(pos_r);
  assign rem_sh     = {rem_r[31:0], low_r[RAMP_Q_W-1]};
  assign rem_sub    = 32'(rem_sh - {1'b0, span_r});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sec_r <= 32'(recip_prod >> RECIP_SHIFT);
      rem_r <= {1'b0, ramp_prod[41:RAMP_Q_W]};
      low_r <= ramp_prod[RAMP_Q_W-1:0];
      q_r   <= '0;
    end else if (cmd.step) begin
      low_r <= {low_r[RAMP_Q_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, span_r}) begin
        rem_r <= {1'b0, rem_sub};
        q_r   <= {q_r[RAMP_Q_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[RAMP_Q_W-2:0], 1'b0};
      end
    end
  end

  logic        lit_nxt, armed_nxt, run_nxt;
  logic [7:0]  duty_nxt;
  logic [9:0]  level_nxt, org_nxt, tgt_nxt;
  logic [31:0] since_nxt, dead_nxt, begin_nxt, finish_nxt;
  logic [31:0] cyc_nxt, sum_nxt, cut_nxt, live;
  logic [1:0]  kind, reason;
  logic        cutf, drv_on, drv_lit, drv_en;
  logic [7:0]  drv_duty, a_duty, p_sat;
  logic [9:0]  drv_level, a_level, l_sat, lvl;
  logic        a_on, reject;
  logic [31:0] lim;

  always_comb begin
    lit_nxt = lit_r;  armed_nxt = off_armed_r;  run_nxt = ramp_running_r;
    duty_nxt = duty_r;  level_nxt = level_r;
    org_nxt = ramp_origin_r;  tgt_nxt = ramp_target_r;
    since_nxt = lit_since_r;  dead_nxt = off_deadline_r;
    begin_nxt = ramp_begin_r;  finish_nxt = ramp_finish_r;
    cyc_nxt = cycles_r;  sum_nxt = on_sum_r;  cut_nxt = cutoffs_r;
    kind = EV_NONE;  reason = RS_NONE;  cutf = 1'b0;
    drv_en = 1'b0;  drv_lit = 1'b0;  drv_duty = '0;  drv_level = '0;
    drv_on = 1'b0;
    a_on = lit_r;  a_duty = duty_r;  a_level = level_r;
    p_sat = c_pwm_r[15] ? 8'd0 : ((c_pwm_r > 16'sd255) ? 8'd255 : c_pwm_r[7:0]);
    l_sat = c_lvl_r[15] ? 10'd0 : ((c_lvl_r > 16'sd1023) ? 10'd1023 : c_lvl_r[9:0]);
    lim = (mode_r == MODE_SWITCH && limit_r == '0) ? DEF_LIM : limit_r;
    lvl = (ramp_target_r >= ramp_origin_r) ? ramp_origin_r + q_r : ramp_origin_r - q_r;
    reject = (mode_r == MODE_SWITCH) ? !(c_hs_r || c_hp_r) : !(c_hs_r || c_hl_r);

    if (c_cmd_r == CMD_APPLY) begin
      if (reject) begin
        kind = EV_REJECTED;
        reason = RS_MISSING;
      end else begin
        kind = EV_CHANGED;
        if (mode_r == MODE_SWITCH) begin
          if (c_hs_r) begin
            a_on = c_son_r;
            a_duty = c_son_r ? 8'd255 : 8'd0;
          end
          if (c_hp_r) begin
            a_duty = p_sat;
            a_on = (p_sat != 8'd0);
          end
        end else begin
          if (c_hl_r) begin
            a_level = l_sat;
            a_on = (l_sat != 10'd0);
          end
          if (c_hs_r && !c_son_r) begin
            a_level = '0;
            a_on = 1'b0;
          end else if (c_hs_r && c_son_r && !c_hl_r) begin
            a_level = 10'd1023;
            a_on = 1'b1;
          end
        end
        if (c_hd_r && c_dsec_r != '0) begin
          dead_nxt = c_now_r + dms_r;
          armed_nxt = 1'b1;
        end
        drv_en = 1'b1;
        drv_duty = a_duty;
        if (mode_r != MODE_SWITCH && c_hr_r && a_on && c_rsec_r != '0) begin
          org_nxt = level_r;
          tgt_nxt = a_level;
          begin_nxt = c_now_r;
          finish_nxt = c_now_r + rms_r;
          run_nxt = 1'b1;
          drv_lit = 1'b1;
          drv_level = level_r;
        end else begin
          if (mode_r != MODE_SWITCH) run_nxt = 1'b0;
          drv_lit = a_on;
          drv_level = a_level;
        end
      end
    end else begin
      if (off_armed_r && !dl_gap[31]) begin
        drv_en = 1'b1;
        cut_nxt = cutoffs_r + 1'b1;
        kind = EV_CHANGED;  reason = RS_TIMER;  cutf = 1'b1;
      end else if (lit_r && lim != '0 && d_r > lim) begin
        drv_en = 1'b1;
        cut_nxt = cutoffs_r + 1'b1;
        kind = EV_CHANGED;  reason = RS_MAX_ON;  cutf = 1'b1;
      end else if (ramp_running_r) begin
        if (!fin_gap[31]) begin
          run_nxt = 1'b0;
          level_nxt = ramp_target_r;
          lit_nxt = (ramp_target_r != '0);
          if (ramp_target_r == '0) duty_nxt = '0;
          kind = EV_CHANGED;
        end else if (span_r != '0 && lvl != level_r) begin
          level_nxt = lvl;
          kind = EV_CHANGED;
        end
      end
    end

    if (drv_en) begin
      lit_nxt = drv_lit;
      duty_nxt = drv_lit ? drv_duty : 8'd0;
      level_nxt = drv_lit ? drv_level : 10'd0;
      if (drv_lit && !lit_r) begin
        since_nxt = c_now_r;
        cyc_nxt = cycles_r + 1'b1;
        drv_on = 1'b1;
      end
      if (!drv_lit && lit_r) begin
        sum_nxt = on_sum_r + sec_r;
        armed_nxt = 1'b0;
        run_nxt = 1'b0;
      end
    end

    live = sum_nxt + ((lit_nxt && !drv_on) ? sec_r : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r <= 1'b0;  off_armed_r <= 1'b0;  ramp_running_r <= 1'b0;
      duty_r <= '0;  level_r <= '0;  ramp_origin_r <= '0;  ramp_target_r <= '0;
      lit_since_r <= '0;  off_deadline_r <= '0;
      ramp_begin_r <= '0;  ramp_finish_r <= '0;
      cycles_r <= '0;  on_sum_r <= '0;  cutoffs_r <= '0;
    end else if (cmd.update) begin
      lit_r <= lit_nxt;  off_armed_r <= armed_nxt;  ramp_running_r <= run_nxt;
      duty_r <= duty_nxt;  level_r <= level_nxt;
      ramp_origin_r <= org_nxt;  ramp_target_r <= tgt_nxt;
      lit_since_r <= since_nxt;  off_deadline_r <= dead_nxt;
      ramp_begin_r <= begin_nxt;  ramp_finish_r <= finish_nxt;
      cycles_r <= cyc_nxt;  on_sum_r <= sum_nxt;  cutoffs_r <= cut_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_event_kind       <= kind;
      out_reason_code      <= reason;
      out_output_on        <= lit_nxt;
      out_pwm_duty         <= duty_nxt;
      out_dim_level        <= level_nxt;
      out_was_cutoff       <= cutf;
      out_ramp_active      <= run_nxt;
      out_cycle_total      <= cyc_nxt;
      out_on_seconds_total <= sum_nxt;
      out_on_seconds_live  <= live;
      out_cutoff_total     <= cut_nxt;
    end
  end

  assign sts.slot_free = !out_valid || out_ready;

endmodule

// ===== rtl/core/output_channel_guard_ramp.sv =====
// Top level of the output channel guard with dim ramp.
// Depends on ocg_pkg, ocg_ctrl and ocg_dp.
//
// Usage: configuration writes arrive on the cfg_ channel (index 0 selects
// the channel mode, index 1 the max-on limit in ms); cfg_ready is always
// high and writes belong in idle periods only.
// Each beat on the in_ channel is an apply command or a time tick and
// yields exactly one beat on the out_ channel.
// From the accepting edge to output valid an item passes a prepare state,
// a multiply state for the seconds conversion and ramp product, the
// radix-2 ramp divider for the ten-bit quotient and an update state.
// One item is in flight at a time; the sequencer takes the next beat only
// after the item before it has left the update state and it is idle again.
// in_ready is high while the sequencer is idle, also while a finished
// result still waits in the output register.
// When the receiver stalls, the next item is held at its update cycle
// until the output register is free.
// Synchronous reset clears the channel state, counters, configuration registers and output valid.
module output_channel_guard_ramp import ocg_pkg::*; #(
  parameter int unsigned MAX_DURATION_SEC  = MAX_DURATION_SEC_DEF,
  parameter int unsigned DEFAULT_MAX_ON_MS = DEFAULT_MAX_ON_MS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [31:0]        in_now_ms,
  input  logic               in_state_given,
  input  logic               in_on_wanted,
  input  logic               in_has_pwm,
  input  logic signed [15:0] in_pwm_request,
  input  logic               in_level_given,
  input  logic signed [15:0] in_level_request,
  input  logic               in_ramp_given,
  input  logic [15:0]        in_ramp_seconds,
  input  logic               in_timer_given,
  input  logic [15:0]        in_duration_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_event_kind,
  output logic [1:0]         out_reason_code,
  output logic               out_output_on,
  output logic [7:0]         out_pwm_duty,
  output logic [9:0]         out_dim_level,
  output logic               out_was_cutoff,
  output logic               out_ramp_active,
  output logic [31:0]        out_cycle_total,
  output logic [31:0]        out_on_seconds_total,
  output logic [31:0]        out_on_seconds_live,
  output logic [31:0]        out_cutoff_total
);

  ocg_cmd_t cmd;
  ocg_sts_t sts;

  assign cfg_ready = 1'b1;

  ocg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ocg_dp #(
    .MAX_DURATION_SEC  (MAX_DURATION_SEC),
    .DEFAULT_MAX_ON_MS (DEFAULT_MAX_ON_MS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_cmd              (in_cmd),
    .in_now_ms           (in_now_ms),
    .in_state_given      (in_state_given),
    .in_on_wanted        (in_on_wanted),
    .in_has_pwm          (in_has_pwm),
    .in_pwm_request      (in_pwm_request),
    .in_level_given      (in_level_given),
    .in_level_request    (in_level_request),
    .in_ramp_given       (in_ramp_given),
    .in_ramp_seconds     (in_ramp_seconds),
    .in_timer_given      (in_timer_given),
    .in_duration_seconds (in_duration_seconds),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_event_kind      (out_event_kind),
    .out_reason_code     (out_reason_code),
    .out_output_on       (out_output_on),
    .out_pwm_duty        (out_pwm_duty),
    .out_dim_level       (out_dim_level),
    .out_was_cutoff      (out_was_cutoff),
    .out_ramp_active     (out_ramp_active),
    .out_cycle_total     (out_cycle_total),
    .out_on_seconds_total(out_on_seconds_total),
    .out_on_seconds_live (out_on_seconds_live),
    .out_cutoff_total    (out_cutoff_total)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("input taken while busy");

  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == EV_NONE) |-> (out_reason_code == RS_NONE && !out_was_cutoff))
    else $error("quiet result carries a reason");

  a_cutoff_is_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_cutoff) |-> !out_output_on) else $error("cutoff left output on");

  a_duty_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pwm_duty != 8'd0) |-> out_output_on) else $error("duty while off");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for output_channel_guard_ramp: a class predicts every result beat.
// Tasks drive both channels with idling, then configuration phases in switch and dim mode.
// Depends on ocg_pkg and the output_channel_guard_ramp RTL.
`timescale 1ns / 100ps

module tb_top;
  import ocg_pkg::*;

  typedef struct {
    logic        cmd;
    logic [31:0] now_ms;
    logic        state_given;
    logic        on_wanted;
    logic        has_pwm;
    logic [15:0] pwm_request;
    logic        level_given;
    logic [15:0] level_request;
    logic        ramp_given;
    logic [15:0] ramp_seconds;
    logic        timer_given;
    logic [15:0] duration_seconds;
  } guard_cmd_t;

  typedef struct {
    logic [1:0]  event_kind;
    logic [1:0]  reason_code;
    logic        output_on;
    logic [7:0]  pwm_duty;
    logic [9:0]  dim_level;
    logic        was_cutoff;
    logic        ramp_active;
    logic [31:0] cycle_total;
    logic [31:0] on_seconds_total;
    logic [31:0] on_seconds_live;
    logic [31:0] cutoff_total;
  } guard_status_t;

  class channel_scoreboard;
    logic        mode_dim;
    logic [31:0] limit_ms;
    logic        lit;
    logic [7:0]  duty_now;
    logic [9:0]  level_now;
    logic [31:0] lit_since;
    logic        off_armed;
    logic [31:0] off_deadline;
    logic        ramp_on;
    logic [9:0]  ramp_from;
    logic [9:0]  ramp_to;
    logic [31:0] ramp_start;
    logic [31:0] ramp_end;
    logic [31:0] cycles;
    logic [31:0] on_sec_sum;
    logic [31:0] cutoffs;
    guard_status_t expected_q[$];
    int errors;

    function void clear();
      mode_dim = 0; limit_ms = 0; lit = 0; duty_now = 0; level_now = 0;
      lit_since = 0; off_armed = 0; off_deadline = 0; ramp_on = 0;
      ramp_from = 0; ramp_to = 0; ramp_start = 0; ramp_end = 0;
      cycles = 0; on_sec_sum = 0; cutoffs = 0; errors = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == CFG_MODE) mode_dim = data[0];
      else limit_ms = data;
    endfunction

    function bit deadline_hit(logic [31:0] now, logic [31:0] dl);
      logic [31:0] d;
      d = now - dl;
      return !d[31];
    endfunction

    function logic [31:0] secs_to_ms(logic [15:0] secs);
      logic [31:0] s;
      s = secs;
      if (s > MAX_DURATION_SEC_DEF) s = MAX_DURATION_SEC_DEF;
      return s * 32'd1000;
    endfunction

    function void drive_channel(logic on, logic [7:0] duty, logic [9:0] level,
                                logic [31:0] now);
      logic was;
      was = lit;
      lit = on;
      duty_now = on ? duty : 8'd0;
      level_now = on ? level : 10'd0;
      if (on && !was) begin
        lit_since = now;
        cycles++;
      end
      if (!on && was) begin
        on_sec_sum += (now - lit_since) / 32'd1000;
        off_armed = 0;
        ramp_on = 0;
      end
    endfunction

    function logic [1:0] apply_command(guard_cmd_t c);
      logic on;
      logic [7:0] duty;
      logic [9:0] level;
      int p;
      on = lit; duty = duty_now; level = level_now;
      if (!mode_dim ? !(c.state_given || c.has_pwm) : !(c.state_given || c.level_given))
        return EV_REJECTED;
      if (!mode_dim) begin
        if (c.state_given) begin
          on = c.on_wanted;
          duty = on ? 8'd255 : 8'd0;
        end
        if (c.has_pwm) begin
          p = $signed(c.pwm_request);
          duty = p < 0 ? 8'd0 : (p > 255 ? 8'd255 : p[7:0]);
          on = duty > 0;
        end
      end else begin
        if (c.level_given) begin
          p = $signed(c.level_request);
          level = p < 0 ? 10'd0 : (p > 1023 ? 10'd1023 : p[9:0]);
          on = level > 0;
        end
        if (c.state_given && !c.on_wanted) begin
          level = 0;
          on = 0;
        end else if (c.state_given && c.on_wanted && !c.level_given) begin
          level = 10'd1023;
          on = 1;
        end
        if (c.ramp_given && on && c.ramp_seconds > 0) begin
          ramp_from = level_now;
          ramp_to = level;
          ramp_start = c.now_ms;
          ramp_end = c.now_ms + secs_to_ms(c.ramp_seconds);
          ramp_on = 1;
          drive_channel(1, duty, ramp_from, c.now_ms);
          if (c.timer_given && c.duration_seconds > 0) begin
            off_deadline = c.now_ms + secs_to_ms(c.duration_seconds);
            off_armed = 1;
          end
          return EV_CHANGED;
        end
        ramp_on = 0;
      end
      if (c.timer_given && c.duration_seconds > 0) begin
        off_deadline = c.now_ms + secs_to_ms(c.duration_seconds);
        off_armed = 1;
      end
      drive_channel(on, duty, level, c.now_ms);
      return EV_CHANGED;
    endfunction

    function logic [1:0] apply_tick(logic [31:0] now, output logic [1:0] reason,
                                    output logic cut);
      logic [31:0] lim, span, pos, mag, q;
      logic [63:0] prod;
      logic [9:0] lvl;
      reason = RS_NONE;
      cut = 0;
      lim = limit_ms;
      if (!mode_dim && lim == 0) lim = DEFAULT_MAX_ON_MS_DEF;
      if (off_armed && deadline_hit(now, off_deadline)) begin
        drive_channel(0, 0, 0, now);
        cutoffs++;
        reason = RS_TIMER;
        cut = 1;
        return EV_CHANGED;
      end
      if (lit && lim > 0 && (now - lit_since) > lim) begin
        drive_channel(0, 0, 0, now);
        cutoffs++;
        reason = RS_MAX_ON;
        cut = 1;
        return EV_CHANGED;
      end
      if (ramp_on) begin
        if (deadline_hit(now, ramp_end)) begin
          ramp_on = 0;
          level_now = ramp_to;
          lit = level_now > 0;
          if (!lit) duty_now = 0;
          return EV_CHANGED;
        end
        span = ramp_end - ramp_start;
        pos = now - ramp_start;
        if (pos > span) pos = span;
        if (span == 0) return EV_NONE;
        mag = ramp_to >= ramp_from ? ramp_to - ramp_from : ramp_from - ramp_to;
        prod = 64'(mag) * 64'(pos);
        q = 32'(prod / 64'(span));
        lvl = 10'(ramp_to >= ramp_from ? 32'(ramp_from) + q : 32'(ramp_from) - q);
        if (lvl != level_now) begin
          level_now = lvl;
          return EV_CHANGED;
        end
      end
      return EV_NONE;
    endfunction

    function void note_input(guard_cmd_t c);
      guard_status_t r;
      r.reason_code = RS_NONE;
      r.was_cutoff = 0;
      if (c.cmd == CMD_APPLY) begin
        r.event_kind = apply_command(c);
        if (r.event_kind == EV_REJECTED) r.reason_code = RS_MISSING;
      end else begin
        r.event_kind = apply_tick(c.now_ms, r.reason_code, r.was_cutoff);
      end
      r.output_on = lit;
      r.pwm_duty = duty_now;
      r.dim_level = level_now;
      r.ramp_active = ramp_on;
      r.cycle_total = cycles;
      r.on_seconds_total = on_sec_sum;
      r.on_seconds_live = on_sec_sum + (lit ? (c.now_ms - lit_since) / 32'd1000 : 32'd0);
      r.cutoff_total = cutoffs;
      expected_q.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(guard_status_t a);
      guard_status_t e;
      if (expected_q.size() == 0) begin
        $error("result beat arrived with no expectation pending");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("event_kind", e.event_kind, a.event_kind);
      compare("reason_code", e.reason_code, a.reason_code);
      compare("output_on", e.output_on, a.output_on);
      compare("pwm_duty", e.pwm_duty, a.pwm_duty);
      compare("dim_level", e.dim_level, a.dim_level);
      compare("was_cutoff", e.was_cutoff, a.was_cutoff);
      compare("ramp_active", e.ramp_active, a.ramp_active);
      compare("cycle_total", e.cycle_total, a.cycle_total);
      compare("on_seconds_total", e.on_seconds_total, a.on_seconds_total);
      compare("on_seconds_live", e.on_seconds_live, a.on_seconds_live);
      compare("cutoff_total", e.cutoff_total, a.cutoff_total);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_cmd = 0;
  logic [31:0] in_now_ms = 0;
  logic in_state_given = 0;
  logic in_on_wanted = 0;
  logic in_has_pwm = 0;
  logic signed [15:0] in_pwm_request = 0;
  logic in_level_given = 0;
  logic signed [15:0] in_level_request = 0;
  logic in_ramp_given = 0;
  logic [15:0] in_ramp_seconds = 0;
  logic in_timer_given = 0;
  logic [15:0] in_duration_seconds = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_event_kind;
  logic [1:0] out_reason_code;
  logic out_output_on;
  logic [7:0] out_pwm_duty;
  logic [9:0] out_dim_level;
  logic out_was_cutoff;
  logic out_ramp_active;
  logic [31:0] out_cycle_total;
  logic [31:0] out_on_seconds_total;
  logic [31:0] out_on_seconds_live;
  logic [31:0] out_cutoff_total;

  output_channel_guard_ramp u_dut (.*);

  always #2 clk = ~clk;

  channel_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  logic [31:0] clock_ms = 0;

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    guard_status_t r;
    if (rst_n && out_valid && out_ready) begin
      r.event_kind = out_event_kind;
      r.reason_code = out_reason_code;
      r.output_on = out_output_on;
      r.pwm_duty = out_pwm_duty;
      r.dim_level = out_dim_level;
      r.was_cutoff = out_was_cutoff;
      r.ramp_active = out_ramp_active;
      r.cycle_total = out_cycle_total;
      r.on_seconds_total = out_on_seconds_total;
      r.on_seconds_live = out_on_seconds_live;
      r.cutoff_total = out_cutoff_total;
      sb.check_result(r);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_cfg(logic idx, logic [31:0] data);
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task automatic send(guard_cmd_t c);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= c.cmd;
    in_now_ms <= c.now_ms;
    in_state_given <= c.state_given;
    in_on_wanted <= c.on_wanted;
    in_has_pwm <= c.has_pwm;
    in_pwm_request <= c.pwm_request;
    in_level_given <= c.level_given;
    in_level_request <= c.level_request;
    in_ramp_given <= c.ramp_given;
    in_ramp_seconds <= c.ramp_seconds;
    in_timer_given <= c.timer_given;
    in_duration_seconds <= c.duration_seconds;
    do @(posedge clk); while (!in_ready);
    sb.note_input(c);
  endtask

  function automatic guard_cmd_t blank(logic cmd, logic [31:0] now);
    guard_cmd_t c;
    c = '{default: 0};
    c.cmd = cmd;
    c.now_ms = now;
    return c;
  endfunction

  function automatic logic [15:0] pick_request(int top);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(top + 300) - 150);
      default: return 16'($urandom_range(top));
    endcase
  endfunction

  function automatic logic [15:0] pick_secs();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic guard_cmd_t random_item();
    guard_cmd_t c;
    case ($urandom_range(19))
      0: clock_ms = $urandom;
      1: clock_ms = clock_ms - $urandom_range(2000);
      2: clock_ms = clock_ms + $urandom_range(4000000);
      default: clock_ms = clock_ms + $urandom_range(900);
    endcase
    c = blank(($urandom_range(99) < 55) ? CMD_TICK : CMD_APPLY, clock_ms);
    if ($urandom_range(19) == 0) begin
      c.state_given = $urandom; c.on_wanted = $urandom; c.has_pwm = $urandom;
      c.level_given = $urandom; c.ramp_given = $urandom; c.timer_given = $urandom;
      c.pwm_request = $urandom; c.level_request = $urandom;
      c.ramp_seconds = $urandom; c.duration_seconds = $urandom;
      return c;
    end
    if (c.cmd == CMD_APPLY) begin
      c.state_given = $urandom_range(99) < 40;
      c.on_wanted = $urandom_range(99) < 75;
      c.has_pwm = $urandom_range(99) < 45;
      c.pwm_request = pick_request(255);
      c.level_given = $urandom_range(99) < 55;
      c.level_request = pick_request(1023);
      c.ramp_given = $urandom_range(99) < 50;
      c.ramp_seconds = pick_secs();
      c.timer_given = $urandom_range(99) < 35;
      c.duration_seconds = pick_secs();
    end
    return c;
  endfunction

  task automatic directed_switch();
    guard_cmd_t c;
    send(blank(CMD_APPLY, 32'd100));
    c = blank(CMD_APPLY, 32'd200); c.state_given = 1; c.on_wanted = 1; send(c);
    c = blank(CMD_APPLY, 32'd300); c.has_pwm = 1; c.pwm_request = -16'sd5; send(c);
    c = blank(CMD_APPLY, 32'd400); c.has_pwm = 1; c.pwm_request = 16'sd300; send(c);
    c = blank(CMD_APPLY, 32'd500); c.has_pwm = 1; c.pwm_request = 16'sh7FFF;
    c.timer_given = 1; c.duration_seconds = 16'hFFFF; send(c);
    c = blank(CMD_APPLY, 32'd600); c.has_pwm = 1; c.pwm_request = 16'sh8000;
    c.timer_given = 1; send(c);
    c = blank(CMD_APPLY, 32'd700); c.state_given = 1; c.on_wanted = 1; send(c);
    send(blank(CMD_TICK, 32'd3600700));
    send(blank(CMD_TICK, 32'd3600701));
    c = blank(CMD_APPLY, 32'hFFFFF000); c.state_given = 1; c.on_wanted = 1;
    c.timer_given = 1; c.duration_seconds = 16'd2; send(c);
    send(blank(CMD_TICK, 32'hFFFFFF00));
    send(blank(CMD_TICK, 32'd2000));
    clock_ms = 32'd2000;
  endtask

  task automatic directed_dim();
    guard_cmd_t c;
    c = blank(CMD_APPLY, clock_ms); c.has_pwm = 1; c.pwm_request = 16'sd50; send(c);
    c = blank(CMD_APPLY, clock_ms); c.level_given = 1; c.level_request = 16'sd1023; send(c);
    c = blank(CMD_APPLY, clock_ms); c.level_given = 1; c.level_request = 16'sd0;
    c.ramp_given = 1; c.ramp_seconds = 16'd2; send(c);
    c = blank(CMD_APPLY, clock_ms); c.level_given = 1; c.level_request = 16'sd100; send(c);
    c = blank(CMD_APPLY, clock_ms); c.level_given = 1; c.level_request = 16'sd900;
    c.ramp_given = 1; c.ramp_seconds = 16'd2; c.timer_given = 1;
    c.duration_seconds = 16'd9; send(c);
    send(blank(CMD_TICK, clock_ms + 500));
    send(blank(CMD_TICK, clock_ms - 100));
    send(blank(CMD_TICK, clock_ms + 2000));
    c = blank(CMD_APPLY, clock_ms + 2100); c.state_given = 1; c.on_wanted = 1;
    c.level_given = 1; c.level_request = 16'sd3; c.ramp_given = 1; c.ramp_seconds = 16'd1;
    send(c);
    send(blank(CMD_TICK, clock_ms + 2600));
    c = blank(CMD_APPLY, clock_ms + 2700); c.state_given = 1; c.on_wanted = 0; send(c);
    clock_ms = clock_ms + 2700;
  endtask

  logic [31:0] limits[8] = '{32'd0, 32'd0, 32'd4000, 32'hFFFFFFFF,
                             32'd1, 32'd2500, 32'd10000, 32'h7FFFFFFF};
  logic modes[8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  initial begin
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 65; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 65; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      write_cfg(CFG_MODE, {31'd0, modes[ph]});
      write_cfg(CFG_LIMIT, limits[ph]);
      if (ph == 0) directed_switch();
      if (ph == 1) directed_dim();
      for (int i = 0; i < 175; i++) begin
        if (ph == 2 && i == 20) hold_cycles = 400;
        send(random_item());
      end
    end
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
